@@ sv/sparse_matrix_entry_table_assert.svh @@
// Assertion macros for the sparse matrix entry table.
// Used by the top level; expects clk and rst in scope.
`ifndef SPARSE_MATRIX_ENTRY_TABLE_ASSERT_SVH
`define SPARSE_MATRIX_ENTRY_TABLE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define SMET_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SMET_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/smet_pkg.sv @@
// Shared types and constants for the sparse matrix entry table.
// No dependencies; used by smet_cell and the top level.
package smet_pkg;

  localparam int DefEntries   = 64;
  localparam int DefCoordBits = 16;
  localparam int DefValueBits = 32;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_READ   = 2'd1,
    OP_REMOVE = 2'd2
  } op_t;

  // Control part of the query token that walks the cell chain.
  typedef struct packed {
    logic       active;
    logic [1:0] op;
    logic       hit;
    logic       free_found;
  } ctl_t;

endpackage

@@ sv/sparse_matrix_entry_table.sv @@
// Sparse matrix entry table: one query token walks a chain of ENTRIES slot cells.
// Depends on smet_pkg, smet_cell and sparse_matrix_entry_table_assert.svh.
//
// Usage:
//   Requests arrive on the s_ group: s_tuser carries the opcode, s_tdata the
//   row, col and write_value. Each transaction yields exactly one result on
//   the m_ group (read_value, found, table_full, entry_count, max_row, max_col).
//   One request is processed at a time. The request token advances one slot
//   cell per cycle; the result is registered after the token leaves the last
//   cell, and the next request is taken only once the token has left it, so
//   no new request enters while one is in the chain, which has one cell per
//   slot.
//   An insert of a new key lands in the lowest free slot once the token has
//   passed all cells and no match was seen.
//   Reset clears every slot's valid bit at once and empties the output stage.
//   A stalled receiver is absorbed by a result register plus one skid entry;
//   besides the busy window, requests are held off while that skid entry is
//   occupied.
module sparse_matrix_entry_table #(
  parameter int ENTRIES    = smet_pkg::DefEntries,
  parameter int COORD_BITS = smet_pkg::DefCoordBits,
  parameter int VALUE_BITS = smet_pkg::DefValueBits,
  localparam int CNT_W     = $clog2(ENTRIES + 1),
  localparam int IN_RAW    = 2 * COORD_BITS + VALUE_BITS,
  localparam int IN_W      = ((IN_RAW + 7) / 8) * 8,
  localparam int OUT_RAW   = VALUE_BITS + 2 + CNT_W + 2 * COORD_BITS,
  localparam int OUT_W     = ((OUT_RAW + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // row, col, write_value (low to high), zero padded
  input  logic [IN_W-1:0]  s_tdata,
  // opcode
  input  logic [1:0]       s_tuser,
  output logic             m_tvalid,
  input  logic             m_tready,
  // read_value, found, table_full, entry_count, max_row, max_col (low to high)
  output logic [OUT_W-1:0] m_tdata
);
  import smet_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);

  ctl_t                  ctl   [ENTRIES+1];
  logic [COORD_BITS-1:0] trow  [ENTRIES+1];
  logic [COORD_BITS-1:0] tcol  [ENTRIES+1];
  logic [VALUE_BITS-1:0] twval [ENTRIES+1];
  logic [VALUE_BITS-1:0] trd   [ENTRIES+1];
  logic [CNT_W-1:0]      tcnt  [ENTRIES+1];
  logic [COORD_BITS-1:0] tmaxr [ENTRIES+1];
  logic [COORD_BITS-1:0] tmaxc [ENTRIES+1];
  logic [IDX_W-1:0]      tfidx [ENTRIES+1];

  logic                  busy;
  logic                  skid_valid;
  logic [OUT_W-1:0]      skid_data;
  logic                  accept;
  logic                  done;

  ctl_t                  tail;
  logic                  ins_req;
  logic                  ins_en;
  logic                  res_full;
  logic                  res_found;
  logic [CNT_W-1:0]      res_count;
  logic [COORD_BITS-1:0] res_maxr;
  logic [COORD_BITS-1:0] res_maxc;
  logic [VALUE_BITS-1:0] res_rd;
  logic [OUT_W-1:0]      res_word;

  assign s_tready = !busy && !skid_valid;
  assign accept   = s_tvalid && s_tready;

  // Load the request into the head of the chain.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl[0] <= '0;
    end else begin
      ctl[0].active     <= accept;
      ctl[0].op         <= s_tuser;
      ctl[0].hit        <= 1'b0;
      ctl[0].free_found <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    trow[0]  <= s_tdata[0 +: COORD_BITS];
    tcol[0]  <= s_tdata[COORD_BITS +: COORD_BITS];
    twval[0] <= s_tdata[2 * COORD_BITS +: VALUE_BITS];
    trd[0]   <= '0;
    tcnt[0]  <= '0;
    tmaxr[0] <= '0;
    tmaxc[0] <= '0;
    tfidx[0] <= '0;
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    smet_cell #(
      .ENTRIES   (ENTRIES),
      .COORD_BITS(COORD_BITS),
      .VALUE_BITS(VALUE_BITS),
      .INDEX     (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl_in   (ctl[i]),
      .row_in   (trow[i]),
      .col_in   (tcol[i]),
      .wval_in  (twval[i]),
      .rdval_in (trd[i]),
      .cnt_in   (tcnt[i]),
      .maxr_in  (tmaxr[i]),
      .maxc_in  (tmaxc[i]),
      .fidx_in  (tfidx[i]),
      .ctl_out  (ctl[i+1]),
      .row_out  (trow[i+1]),
      .col_out  (tcol[i+1]),
      .wval_out (twval[i+1]),
      .rdval_out(trd[i+1]),
      .cnt_out  (tcnt[i+1]),
      .maxr_out (tmaxr[i+1]),
      .maxc_out (tmaxc[i+1]),
      .fidx_out (tfidx[i+1]),
      .ins_en   (ins_en),
      .ins_idx  (tfidx[ENTRIES]),
      .ins_row  (trow[ENTRIES]),
      .ins_col  (tcol[ENTRIES]),
      .ins_val  (twval[ENTRIES])
    );
  end

  // Finish the operation as the token leaves the last cell.
  assign tail      = ctl[ENTRIES];
  assign done      = tail.active;
  assign ins_req   = done && (tail.op == OP_WRITE) && (|twval[ENTRIES]) && !tail.hit;
  assign ins_en    = ins_req && tail.free_found;
  assign res_full  = ins_req && !tail.free_found;
  assign res_found = tail.hit && ((tail.op == OP_WRITE) || (tail.op == OP_READ) ||
                                  (tail.op == OP_REMOVE));
  assign res_rd    = trd[ENTRIES];
  assign res_count = tcnt[ENTRIES] + CNT_W'(ins_en);
  assign res_maxr  = (ins_en && (trow[ENTRIES] > tmaxr[ENTRIES])) ? trow[ENTRIES]
                                                                  : tmaxr[ENTRIES];
  assign res_maxc  = (ins_en && (tcol[ENTRIES] > tmaxc[ENTRIES])) ? tcol[ENTRIES]
                                                                  : tmaxc[ENTRIES];
  assign res_word  = OUT_W'({res_maxc, res_maxr, res_count, res_full, res_found, res_rd});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  // Result register with one skid entry behind it. The skid entry is empty
  // whenever a token finishes, since it blocks new requests.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (done) begin
      if (!m_tvalid || (m_tready && !skid_valid)) begin
        m_tdata  <= res_word;
        m_tvalid <= 1'b1;
      end else begin
        skid_data  <= res_word;
        skid_valid <= 1'b1;
      end
    end else if (m_tvalid && m_tready) begin
      if (skid_valid) begin
        m_tdata    <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= 1'b0;
      end
    end
  end

  `include "sparse_matrix_entry_table_assert.svh"

  `SMET_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted transaction did not start the chain")
  `SMET_ASSERT_NOW(a_skid_behind_out, skid_valid, m_tvalid, "skid entry held with empty output")
  `SMET_ASSERT_NOW(a_full_count, done && res_full, res_count == CNT_W'(ENTRIES), "drop with free slot")
  `SMET_ASSERT_NOW(a_count_bound, done, res_count <= CNT_W'(ENTRIES), "entry count above capacity")

endmodule

@@ sv/smet_cell.sv @@
// One slot of the entry table: holds a key/value and processes the passing token.
// Depends on smet_pkg.
module smet_cell #(
  parameter int ENTRIES    = smet_pkg::DefEntries,
  parameter int COORD_BITS = smet_pkg::DefCoordBits,
  parameter int VALUE_BITS = smet_pkg::DefValueBits,
  parameter int INDEX      = 0,
  localparam int IDX_W     = $clog2(ENTRIES),
  localparam int CNT_W     = $clog2(ENTRIES + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  smet_pkg::ctl_t        ctl_in,
  input  logic [COORD_BITS-1:0] row_in,
  input  logic [COORD_BITS-1:0] col_in,
  input  logic [VALUE_BITS-1:0] wval_in,
  input  logic [VALUE_BITS-1:0] rdval_in,
  input  logic [CNT_W-1:0]      cnt_in,
  input  logic [COORD_BITS-1:0] maxr_in,
  input  logic [COORD_BITS-1:0] maxc_in,
  input  logic [IDX_W-1:0]      fidx_in,
  output smet_pkg::ctl_t        ctl_out,
  output logic [COORD_BITS-1:0] row_out,
  output logic [COORD_BITS-1:0] col_out,
  output logic [VALUE_BITS-1:0] wval_out,
  output logic [VALUE_BITS-1:0] rdval_out,
  output logic [CNT_W-1:0]      cnt_out,
  output logic [COORD_BITS-1:0] maxr_out,
  output logic [COORD_BITS-1:0] maxc_out,
  output logic [IDX_W-1:0]      fidx_out,
  input  logic                  ins_en,
  input  logic [IDX_W-1:0]      ins_idx,
  input  logic [COORD_BITS-1:0] ins_row,
  input  logic [COORD_BITS-1:0] ins_col,
  input  logic [VALUE_BITS-1:0] ins_val
);
  import smet_pkg::*;

  logic                  valid;
  logic [COORD_BITS-1:0] key_row;
  logic [COORD_BITS-1:0] key_col;
  logic [VALUE_BITS-1:0] value;

  logic                  match;
  logic                  do_remove;
  logic                  do_update;
  logic                  keep;
  logic                  ins_here;
  ctl_t                  ctl_next;
  logic [VALUE_BITS-1:0] rdval_next;
  logic [CNT_W-1:0]      cnt_next;
  logic [COORD_BITS-1:0] maxr_next;
  logic [COORD_BITS-1:0] maxc_next;
  logic [IDX_W-1:0]      fidx_next;

  assign match     = ctl_in.active && valid && (key_row == row_in) && (key_col == col_in);
  assign do_remove = match && (ctl_in.op == OP_REMOVE);
  assign do_update = match && (ctl_in.op == OP_WRITE) && (|wval_in);
  // A slot being removed by this token no longer counts toward totals.
  assign keep      = valid && !do_remove;
  assign ins_here  = ins_en && (ins_idx == IDX_W'(INDEX));

  always_comb begin
    ctl_next     = ctl_in;
    ctl_next.hit = ctl_in.hit || match;
    rdval_next   = (match && (ctl_in.op == OP_READ)) ? value : rdval_in;
    cnt_next     = cnt_in + CNT_W'(keep);
    maxr_next    = (keep && (key_row > maxr_in)) ? key_row : maxr_in;
    maxc_next    = (keep && (key_col > maxc_in)) ? key_col : maxc_in;
    fidx_next    = fidx_in;
    if (!valid && !ctl_in.free_found) begin
      ctl_next.free_found = 1'b1;
      fidx_next           = IDX_W'(INDEX);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ins_here) begin
      valid <= 1'b1;
    end else if (do_remove) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ins_here) begin
      key_row <= ins_row;
      key_col <= ins_col;
      value   <= ins_val;
    end else if (do_update) begin
      value <= wval_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_next;
    end
  end

  always_ff @(posedge clk) begin
    row_out   <= row_in;
    col_out   <= col_in;
    wval_out  <= wval_in;
    rdval_out <= rdval_next;
    cnt_out   <= cnt_next;
    maxr_out  <= maxr_next;
    maxc_out  <= maxc_next;
    fidx_out  <= fidx_next;
  end

endmodule

@@ test/sparse_matrix_entry_table_tb.sv @@
`timescale 1ns / 100ps
// Testbench for sparse_matrix_entry_table: drives write/read/remove and unused-opcode requests and
// checks every result against a behavioral copy of the entry table.
// Depends on smet_pkg and the sparse_matrix_entry_table RTL.
module sparse_matrix_entry_table_tb;
  import smet_pkg::*;

  localparam int Entries    = DefEntries;
  localparam int CoordBits  = DefCoordBits;
  localparam int ValueBits  = DefValueBits;
  localparam int CntWidth   = $clog2(Entries + 1);
  localparam int InRaw      = 2 * CoordBits + ValueBits;
  localparam int InWidth    = ((InRaw + 7) / 8) * 8;
  localparam int OutRaw     = ValueBits + 2 + CntWidth + 2 * CoordBits;
  localparam int OutWidth   = ((OutRaw + 7) / 8) * 8;
  localparam int Latency    = Entries + 2;
  localparam int KeyPool    = 72;
  localparam int BurstLen   = 100;
  localparam int RandomItems = 1300;
  localparam int HoldOffLen = 800;
  localparam int CycleLimit = 2000000;
  localparam int MaxPrinted = 40;
  localparam logic [1:0] OpUnused = 2'd3;

  typedef struct packed {
    logic [1:0]                  op;
    logic [CoordBits-1:0]        row;
    logic [CoordBits-1:0]        col;
    logic signed [ValueBits-1:0] value;
  } request_t;

  typedef struct packed {
    logic signed [ValueBits-1:0] read_value;
    logic                        found;
    logic                        table_full;
    logic [CntWidth-1:0]         entry_count;
    logic [CoordBits-1:0]        max_row;
    logic [CoordBits-1:0]        max_col;
  } answer_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InWidth-1:0]  s_tdata = '0;
  logic [1:0]          s_tuser = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutWidth-1:0] m_tdata;

  // Shadow copy of the table contents.
  logic                        slot_valid [Entries];
  logic [CoordBits-1:0]        slot_row   [Entries];
  logic [CoordBits-1:0]        slot_col   [Entries];
  logic signed [ValueBits-1:0] slot_value [Entries];

  logic [CoordBits-1:0] key_row [KeyPool];
  logic [CoordBits-1:0] key_col [KeyPool];

  request_t request_q[$];
  answer_t  answer_q[$];
  request_t cur_req;

  int          send_idle = 0;
  int          recv_idle = 0;
  int          answers_seen = 0;
  int          error_count = 0;
  logic [31:0] cycle_count = '0;
  logic        hold_off = 1'b0;
  logic        quiet_phase;

  // One stretch in four, set by cycle_count bits 13:12, runs without idling on either side.
  assign quiet_phase = (cycle_count[13:12] == 2'b01);

  sparse_matrix_entry_table uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    if (error_count < MaxPrinted)
      $display("mismatch at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet_phase || roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 40);
    return $urandom_range(60, 150);
  endfunction

  task automatic queue_req(input logic [1:0] op, input logic [CoordBits-1:0] row,
                           input logic [CoordBits-1:0] col,
                           input logic signed [ValueBits-1:0] value);
    request_t req;
    req.op = op;
    req.row = row;
    req.col = col;
    req.value = value;
    request_q.push_back(req);
  endtask

  // Apply one request to the shadow table and queue the answer it must give.
  task automatic apply_table_op(input request_t req);
    answer_t ans;
    int      hit;
    int      free_idx;
    int      count;
    ans = '0;
    hit = -1;
    free_idx = -1;
    count = 0;
    for (int i = 0; i < Entries; i++) begin
      if (hit < 0 && slot_valid[i] && slot_row[i] == req.row && slot_col[i] == req.col)
        hit = i;
      if (free_idx < 0 && !slot_valid[i])
        free_idx = i;
    end
    case (req.op)
      OP_WRITE: begin
        ans.found = (hit >= 0);
        if (req.value != 0) begin
          if (hit >= 0) begin
            slot_value[hit] = req.value;
          end else if (free_idx >= 0) begin
            slot_valid[free_idx] = 1'b1;
            slot_row[free_idx] = req.row;
            slot_col[free_idx] = req.col;
            slot_value[free_idx] = req.value;
          end else begin
            ans.table_full = 1'b1;
          end
        end
      end
      OP_READ: begin
        if (hit >= 0) begin
          ans.found = 1'b1;
          ans.read_value = slot_value[hit];
        end
      end
      OP_REMOVE: begin
        if (hit >= 0) begin
          ans.found = 1'b1;
          slot_valid[hit] = 1'b0;
        end
      end
      default: ;
    endcase
    for (int i = 0; i < Entries; i++) begin
      if (slot_valid[i]) begin
        count++;
        if (slot_row[i] > ans.max_row) ans.max_row = slot_row[i];
        if (slot_col[i] > ans.max_col) ans.max_col = slot_col[i];
      end
    end
    ans.entry_count = count[CntWidth-1:0];
    answer_q.push_back(ans);
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  task automatic check_answer(input logic [OutWidth-1:0] word);
    answer_t want;
    if (answer_q.size() == 0) begin
      report_mismatch($sformatf("result 0x%0h with nothing outstanding", word));
    end else begin
      want = answer_q.pop_front();
      check_field("read_value", word[ValueBits-1:0], $unsigned(want.read_value));
      check_field("found", word[ValueBits], want.found);
      check_field("table_full", word[ValueBits+1], want.table_full);
      check_field("entry_count", word[ValueBits+2 +: CntWidth], want.entry_count);
      check_field("max_row", word[ValueBits+2+CntWidth +: CoordBits], want.max_row);
      check_field("max_col", word[ValueBits+2+CntWidth+CoordBits +: CoordBits],
                  want.max_col);
    end
  endtask

  // Request driver: hold each request until the block takes it.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_idle <= 0;
    end else begin
      if (s_tvalid && s_tready)
        apply_table_op(cur_req);
      if (!s_tvalid || s_tready) begin
        if (send_idle > 0) begin
          send_idle <= send_idle - 1;
          s_tvalid <= 1'b0;
        end else if (request_q.size() != 0) begin
          cur_req = request_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= InWidth'({cur_req.value, cur_req.col, cur_req.row});
          s_tuser <= cur_req.op;
          send_idle <= pick_gap();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      recv_idle <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        check_answer(m_tdata);
        answers_seen <= answers_seen + 1;
      end
      if (hold_off) begin
        m_tready <= 1'b0;
      end else if (recv_idle > 0) begin
        recv_idle <= recv_idle - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        recv_idle <= pick_gap();
      end
    end
  end

  // Long receiver stall so the output buffer fills and the input backs up.
  initial begin
    wait (answers_seen >= 300);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HoldOffLen) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("sparse_matrix_entry_table_tb: FAIL");
      $finish;
    end
  end

  initial begin
    int                          mode;
    int                          roll;
    int                          idx;
    int                          fill_ptr;
    logic [1:0]                  op;
    logic [CoordBits-1:0]        row;
    logic [CoordBits-1:0]        col;
    logic signed [ValueBits-1:0] value;
    fill_ptr = 0;
    for (int i = 0; i < Entries; i++) slot_valid[i] = 1'b0;
    for (int k = 0; k < KeyPool; k++) begin
      key_row[k] = CoordBits'($urandom_range(0, 65535));
      key_col[k] = CoordBits'($urandom_range(0, 65535));
    end
    key_row[0] = '0; key_col[0] = '0;
    key_row[1] = '1; key_col[1] = '1;
    key_row[2] = '0; key_col[2] = '1;
    key_row[3] = '1; key_col[3] = '0;

    // Directed: empty table, zero writes, overwrite, extremes, removes.
    queue_req(OP_READ,   16'd0,     16'd0,     32'sd0);
    queue_req(OP_WRITE,  16'd0,     16'd0,     32'sd0);
    queue_req(OP_REMOVE, 16'd0,     16'd0,     32'sd0);
    queue_req(OP_WRITE,  16'hffff,  16'h0000,  32'h7fff_ffff);
    queue_req(OP_WRITE,  16'h0000,  16'hffff,  32'h8000_0000);
    queue_req(OP_WRITE,  16'hffff,  16'h0000,  -32'sd1);
    queue_req(OP_READ,   16'hffff,  16'h0000,  32'sd0);
    queue_req(OP_WRITE,  16'h0000,  16'hffff,  32'sd0);
    queue_req(OP_READ,   16'h0000,  16'hffff,  32'sd5);
    queue_req(OpUnused,  16'hffff,  16'hffff,  -32'sd1);
    queue_req(OP_REMOVE, 16'hffff,  16'h0000,  32'sd0);
    queue_req(OP_REMOVE, 16'hffff,  16'h0000,  32'sd0);
    queue_req(OP_WRITE,  16'd1234,  16'd4321,  32'sd1);
    queue_req(OP_READ,   16'd1,     16'd1,     32'sd0);
    queue_req(OP_REMOVE, 16'h0000,  16'hffff,  32'sd0);
    queue_req(OP_READ,   16'h0000,  16'hffff,  32'sd0);
    queue_req(OP_REMOVE, 16'd1234,  16'd4321,  32'sd0);
    queue_req(OpUnused,  16'd0,     16'd0,     32'sd0);

    // Random bursts cycle through fill, mixed and drain traffic.
    for (int n = 0; n < RandomItems; n++) begin
      mode = (n / BurstLen) % 3;
      roll = $urandom_range(0, 99);
      if (mode == 0) begin
        if (roll < 88) op = OP_WRITE;
        else if (roll < 94) op = OP_READ;
        else if (roll < 98) op = OP_REMOVE;
        else op = OpUnused;
      end else if (mode == 1) begin
        if (roll < 45) op = OP_WRITE;
        else if (roll < 75) op = OP_READ;
        else if (roll < 95) op = OP_REMOVE;
        else op = OpUnused;
      end else begin
        if (roll < 15) op = OP_WRITE;
        else if (roll < 45) op = OP_READ;
        else if (roll < 95) op = OP_REMOVE;
        else op = OpUnused;
      end

      roll = $urandom_range(0, 99);
      if (roll < 5 || (mode != 0 && roll < 15)) begin
        row = CoordBits'($urandom_range(0, 65535));
        col = CoordBits'($urandom_range(0, 65535));
      end else begin
        // Walk the key pool in order while filling so the table overflows.
        if (mode == 0 && roll < 90) begin
          idx = fill_ptr % KeyPool;
          fill_ptr++;
        end else begin
          idx = $urandom_range(0, KeyPool - 1);
        end
        row = key_row[idx];
        col = key_col[idx];
      end

      roll = $urandom_range(0, 99);
      if (roll < 8) value = '0;
      else if (roll < 11) value = 32'h8000_0000;
      else if (roll < 14) value = 32'h7fff_ffff;
      else if (roll < 16) value = '1;
      else value = $urandom;
      queue_req(op, row, col, value);
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (request_q.size() != 0 || s_tvalid) @(negedge clk);
    while (answer_q.size() != 0) @(negedge clk);
    repeat (2 * Latency + 10) @(posedge clk);
    if (error_count == 0) begin
      $display("sparse_matrix_entry_table_tb: PASS");
    end else begin
      $display("sparse_matrix_entry_table_tb: FAIL");
    end
    $finish;
  end

endmodule
